// ===== src/particle_low_pulse_occupancy_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the low-pulse occupancy block. Every macro
// samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_LOW_PULSE_OCCUPANCY_MACROS_SVH
`define PARTICLE_LOW_PULSE_OCCUPANCY_MACROS_SVH

// same-cycle implication
`define PLPO_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLPO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/plpo_pkg.sv =====
// ----------------------------------------------------------------------------
// plpo_pkg
// Widths and fixed-point constants of the low-pulse occupancy block.
// ----------------------------------------------------------------------------
package plpo_pkg;

	localparam int TIME_BITS = 26;
	localparam int FRAC_BITS = 16;
	localparam int COUNT_W   = 17;

	// 100 fits in PCT_W bits, 100^3 in 20 bits
	localparam int PCT_W  = 7;
	localparam int R_W    = FRAC_BITS + PCT_W;
	localparam int R2_W   = 2 * PCT_W + FRAC_BITS;
	localparam int R3_W   = 20 + FRAC_BITS;
	localparam int ACC_W  = R3_W + 2;
	localparam int NEG_W  = R2_W + 2;
	localparam int CONC_W = 21;

	localparam int MA_W = R3_W;
	localparam int MB_W = (R_W > 20) ? R_W : 20;
	localparam int P_W  = MA_W + MB_W;

	localparam int STEP_W = $clog2(R_W);

	localparam logic [R_W-1:0]  R_MAX   = R_W'(64'd100 << FRAC_BITS);
	localparam logic [MB_W-1:0] C3_FX   = MB_W'(((64'd11 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [MB_W-1:0] C2_FX   = MB_W'(((64'd38 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [MB_W-1:0] C1_INT  = MB_W'(520);

	// floor(x/10) = (x * DIV10_M) >> DIV10_SH for x < 2^22
	localparam int              DIV10_SH = 23;
	localparam logic [MB_W-1:0] DIV10_M  = MB_W'(((64'd1 << DIV10_SH) + 64'd9) / 64'd10);

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(111400);

endpackage

// ===== src/plpo_div.sv =====
// ----------------------------------------------------------------------------
// plpo_div
// Iterative restoring divider: ratio = min(total*100*2^FRAC_BITS/window,
// 100*2^FRAC_BITS), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plpo_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [plpo_pkg::TIME_BITS-1:0] total,
	input  logic [plpo_pkg::TIME_BITS-1:0] window,
	output logic                           done,
	output logic [plpo_pkg::R_W-1:0]       ratio
);
	import plpo_pkg::*;

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_DONE = 3'b100
	} div_state_t;

	div_state_t              state_q;
	logic [TIME_BITS-1:0]    rem_q;
	logic [R_W-1:0]          lo_q;
	logic [STEP_W-1:0]       step_q;

	logic [TIME_BITS+PCT_W-1:0] t_ext;
	logic [TIME_BITS+PCT_W-1:0] t100;
	logic [TIME_BITS:0]         rem_sh;
	logic                       ge;
	logic [TIME_BITS:0]         rem_nx;

	always_comb begin
		t_ext  = (TIME_BITS+PCT_W)'(total);
		t100   = (t_ext << 6) + (t_ext << 5) + (t_ext << 2);
		rem_sh = {rem_q, lo_q[R_W-1]};
		ge     = (rem_sh >= {1'b0, window});
		rem_nx = ge ? (rem_sh - {1'b0, window}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						if (total >= window) begin
							state_q <= D_DONE;
						end else begin
							state_q <= D_RUN;
							step_q  <= STEP_W'(R_W - 1);
						end
					end
				end
				D_RUN: begin
					if (step_q == '0) begin
						state_q <= D_DONE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				D_DONE: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			if (total >= window) begin
				lo_q <= (total == '0) ? '0 : R_MAX;
			end else begin
				rem_q <= t100[TIME_BITS+PCT_W-1:PCT_W];
				lo_q  <= {t100[PCT_W-1:0], FRAC_BITS'(0)};
			end
		end else if (state_q == D_RUN) begin
			rem_q <= rem_nx[TIME_BITS-1:0];
			lo_q  <= {lo_q[R_W-2:0], ge};
		end
	end

	assign done  = (state_q == D_DONE);
	assign ratio = lo_q;

endmodule

// ===== src/plpo_poly.sv =====
// ----------------------------------------------------------------------------
// plpo_poly
// Concentration cubic 1.1r^3 - 3.8r^2 + 520r, clamp at zero and divide by
// ten, sequenced over one shared registered multiplier.
// ----------------------------------------------------------------------------
module plpo_poly (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [plpo_pkg::R_W-1:0]     ratio,
	output logic                         done,
	output logic [plpo_pkg::COUNT_W-1:0] count
);
	import plpo_pkg::*;

	typedef enum logic [9:0] {
		P_IDLE = 10'b0000000001,
		P_SQ   = 10'b0000000010,
		P_CUBE = 10'b0000000100,
		P_C3   = 10'b0000001000,
		P_C2   = 10'b0000010000,
		P_C1   = 10'b0000100000,
		P_SUM  = 10'b0001000000,
		P_SUB  = 10'b0010000000,
		P_TEN  = 10'b0100000000,
		P_DONE = 10'b1000000000
	} poly_state_t;

	poly_state_t        state_q;
	logic [R_W-1:0]     r_q;
	logic [R2_W-1:0]    r2_q;
	logic [ACC_W-1:0]   acc_q;
	logic [NEG_W-1:0]   neg_q;
	logic [CONC_W-1:0]  diff_q;
	logic [P_W-1:0]     p_q;

	logic [MA_W-1:0]    ma;
	logic [MB_W-1:0]    mb;
	logic [ACC_W:0]     dsub;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			P_SQ: begin
				ma = MA_W'(r_q);
				mb = MB_W'(r_q);
			end
			P_CUBE: begin
				ma = MA_W'(p_q[FRAC_BITS +: R2_W]);
				mb = MB_W'(r_q);
			end
			P_C3: begin
				ma = p_q[FRAC_BITS +: R3_W];
				mb = C3_FX;
			end
			P_C2: begin
				ma = MA_W'(r2_q);
				mb = C2_FX;
			end
			P_C1: begin
				ma = MA_W'(r_q);
				mb = C1_INT;
			end
			P_TEN: begin
				ma = MA_W'(diff_q);
				mb = DIV10_M;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		dsub = {1'b0, acc_q} - {1'b0, ACC_W'(neg_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
		end else begin
			unique case (state_q)
				P_IDLE:  if (start) state_q <= P_SQ;
				P_SQ:    state_q <= P_CUBE;
				P_CUBE:  state_q <= P_C3;
				P_C3:    state_q <= P_C2;
				P_C2:    state_q <= P_C1;
				P_C1:    state_q <= P_SUM;
				P_SUM:   state_q <= P_SUB;
				P_SUB:   state_q <= P_TEN;
				P_TEN:   state_q <= P_DONE;
				P_DONE:  state_q <= P_IDLE;
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_q <= P_W'(ma) * P_W'(mb);
		if (state_q == P_IDLE && start) begin
			r_q <= ratio;
		end
		if (state_q == P_CUBE) begin
			r2_q <= p_q[FRAC_BITS +: R2_W];
		end
		if (state_q == P_C2) begin
			acc_q <= p_q[FRAC_BITS +: ACC_W];
		end else if (state_q == P_SUM) begin
			acc_q <= acc_q + p_q[ACC_W-1:0];
		end
		if (state_q == P_C1) begin
			neg_q <= p_q[FRAC_BITS +: NEG_W];
		end
		if (state_q == P_SUB) begin
			diff_q <= dsub[ACC_W] ? '0 : dsub[FRAC_BITS +: CONC_W];
		end
	end

	assign done  = (state_q == P_DONE);
	assign count = p_q[DIV10_SH +: COUNT_W];

endmodule

// ===== src/particle_low_pulse_occupancy.sv =====
// ----------------------------------------------------------------------------
// particle_low_pulse_occupancy
// Pulse transfers are taken while idle and return no result. A finish
// transfer runs, per channel, a start step, the divider (or its short path
// when the total reaches the window) and the multiplier sequence, then an
// output step; no input is taken meanwhile or while the result waits on a stalled output.
// Reset clears both totals, the sequencer and the output valid.
// ----------------------------------------------------------------------------
`include "particle_low_pulse_occupancy_macros.svh"

module particle_low_pulse_occupancy (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic                           channel,
	input  logic [plpo_pkg::TIME_BITS-1:0] duration_us,
	input  logic [plpo_pkg::TIME_BITS-1:0] window_time_us,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [plpo_pkg::COUNT_W-1:0]   count_small,
	output logic [plpo_pkg::COUNT_W-1:0]   count_large
);
	import plpo_pkg::*;

	typedef enum logic [4:0] {
		T_IDLE  = 5'b00001,
		T_START = 5'b00010,
		T_DIV   = 5'b00100,
		T_POLY  = 5'b01000,
		T_WAIT  = 5'b10000
	} top_state_t;

	top_state_t             state_q;
	logic [TIME_BITS-1:0]   tot_small_q;
	logic [TIME_BITS-1:0]   tot_large_q;
	logic [TIME_BITS-1:0]   window_q;
	logic                   chan_q;
	logic [COUNT_W-1:0]     small_q;
	logic [COUNT_W-1:0]     large_q;
	logic                   out_valid_q;
	logic [COUNT_W-1:0]     count_small_q;
	logic [COUNT_W-1:0]     count_large_q;

	logic                   accept;
	logic                   out_free;
	logic [TIME_BITS:0]     sum;
	logic [TIME_BITS-1:0]   sum_sat;
	logic                   div_done;
	logic [R_W-1:0]         div_ratio;
	logic                   poly_done;
	logic [COUNT_W-1:0]     poly_count;

	assign in_stall = (state_q != T_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sum     = channel ? ({1'b0, tot_large_q} + {1'b0, duration_us})
		                  : ({1'b0, tot_small_q} + {1'b0, duration_us});
		sum_sat = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
	end

	plpo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == T_START),
		.total  (chan_q ? tot_large_q : tot_small_q),
		.window (window_q),
		.done   (div_done),
		.ratio  (div_ratio)
	);

	plpo_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == T_DIV) && div_done),
		.ratio  (div_ratio),
		.done   (poly_done),
		.count  (poly_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			tot_small_q <= '0;
			tot_large_q <= '0;
			chan_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == T_WAIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (mode) begin
							chan_q  <= 1'b0;
							state_q <= T_START;
						end else if (channel) begin
							tot_large_q <= sum_sat;
						end else begin
							tot_small_q <= sum_sat;
						end
					end
				end
				T_START: begin
					state_q <= T_DIV;
				end
				T_DIV: begin
					if (div_done) begin
						state_q <= T_POLY;
					end
				end
				T_POLY: begin
					if (poly_done) begin
						if (!chan_q) begin
							chan_q  <= 1'b1;
							state_q <= T_START;
						end else begin
							state_q <= T_WAIT;
						end
					end
				end
				T_WAIT: begin
					if (out_free) begin
						tot_small_q <= '0;
						tot_large_q <= '0;
						chan_q      <= 1'b0;
						state_q     <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mode) begin
			window_q <= window_time_us;
		end
		if (state_q == T_POLY && poly_done) begin
			if (chan_q) begin
				large_q <= poly_count;
			end else begin
				small_q <= poly_count;
			end
		end
		if (state_q == T_WAIT && out_free) begin
			count_small_q <= small_q;
			count_large_q <= large_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign count_small = count_small_q;
	assign count_large = count_large_q;

	`PLPO_ASSERT_IMPLY(a_small_range, out_valid, count_small <= COUNT_MAX, "small count out of range")
	`PLPO_ASSERT_IMPLY(a_large_range, out_valid, count_large <= COUNT_MAX, "large count out of range")
	`PLPO_ASSERT_NEXT(a_finish_busy, in_valid && !in_stall && mode, in_stall, "finish transfer did not start work")
	`PLPO_ASSERT_IMPLY(a_totals_clear, $rose(out_valid), tot_small_q == '0 && tot_large_q == '0, "totals not cleared with result")

endmodule
